// ----- design/pnt_pkg.sv -----
// Package for the curved PN triangle patch evaluator.
// Holds operation codes, sequencer states, edge plan tables and small helpers.
// Depends on nothing; imported by pn_triangle_patch_evaluator.
package pnt_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_CORNER = 2'd0,
        OP_LOAD_NORMAL = 2'd1,
        OP_BUILD       = 2'd2,
        OP_EVAL        = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CPY,
        ST_ELD,
        ST_EDOT,
        ST_ETERM,
        ST_EPREP,
        ST_CPREP,
        ST_MAG,
        ST_DIV,
        ST_FIN,
        ST_EWGT,
        ST_EMAC,
        ST_EOUT
    } state_t;

    localparam int unsigned NUM_CORNERS    = 3;
    localparam int unsigned NUM_NORMALS    = 6;
    localparam int unsigned NUM_EDGES      = 6;
    localparam int unsigned GEO_ROWS       = NUM_CORNERS + NUM_NORMALS;
    localparam int unsigned NORMAL_BASE    = NUM_CORNERS;
    localparam int unsigned CTRL_ROWS      = 10;
    localparam int unsigned FIRST_EDGE_ROW = 3;
    localparam int unsigned CENTRE_ROW     = 9;
    localparam int unsigned WEIGHT_FRAC    = 24;
    localparam int unsigned DIV_STEPS      = 2;
    localparam int unsigned WGT_STEPS      = 14;
    localparam int unsigned MAC_STEPS      = 30;

    localparam logic [16:0]        BARY_ONE   = 17'd65536;
    localparam logic [32:0]        DIV_LIMIT  = 33'h1_8000_0000;
    // Low part of 2^34/3 rounded up; its top bit 2^32 is applied as a shift.
    localparam logic [32:0]        RECIP3_LOW = 33'h0_5555_5556;
    localparam logic signed [31:0] SAT_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN    = 32'sh8000_0000;

    // Edge k runs from corner edge_from to corner edge_to using normal edge_nrm;
    // edge_flag selects the straight bit that governs it.
    function automatic logic [1:0] edge_from(input logic [2:0] e);
        logic [1:0] r;
        case (e)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd1;
            3'd3:    r = 2'd2;
            3'd4:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] edge_to(input logic [2:0] e);
        logic [1:0] r;
        case (e)
            3'd0:    r = 2'd1;
            3'd1:    r = 2'd0;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd1;
            3'd4:    r = 2'd0;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] edge_nrm(input logic [2:0] e);
        return e;
    endfunction

    function automatic logic [1:0] edge_flag(input logic [2:0] e);
        logic [1:0] r;
        case (e)
            3'd0, 3'd1: r = 2'd0;
            3'd2, 3'd3: r = 2'd1;
            default:    r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] comp_of(input logic [95:0] row,
                                                   input logic [1:0] c);
        logic signed [31:0] r;
        case (c)
            2'd0:    r = row[31:0];
            2'd1:    r = row[63:32];
            default: r = row[95:64];
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [69:0] x);
        logic signed [31:0] r;
        if (x > 70'(SAT_MAX)) begin
            r = SAT_MAX;
        end
        else if (x < 70'(SAT_MIN)) begin
            r = SAT_MIN;
        end
        else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic [16:0] clamp_bary(input logic [16:0] b);
        return (b > BARY_ONE) ? BARY_ONE : b;
    endfunction

endpackage

// ----- design/pn_triangle_patch_evaluator.sv -----
// Top level of the curved PN triangle patch evaluator (cubic Bezier triangle).
// Uses pnt_pkg for codes, states, edge tables and saturation helpers.
//
// Load transactions may follow back to back.
// An evaluate transaction forms the ten Bernstein weights, then streams thirty control point
// components through the one shared multiplier, then loads the result into the output
// register once that register is free.
// A build transaction holds the input off while it copies the corners, then forms each
// edge point and each centre component, each component passing through the shared multiplier
// and a divide by three. Reset clears the sequencer and the output, weight and multiply-accumulate
// valid flags only; the geometry and control point memories hold nothing until written.
module pn_triangle_patch_evaluator
    import pnt_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic [2:0]         slot,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic [2:0]         straight_edges,
    input  logic [16:0]        bary_u,
    input  logic [16:0]        bary_v,
    input  logic [16:0]        bary_w,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z
);

    // Rounding constant for products that carry twice the fraction bits.
    localparam logic signed [67:0] FRAC_HALF = 68'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [61:0] WGT_HALF  = 62'sd1 <<< (WEIGHT_FRAC - 1);

    function automatic logic signed [67:0] rnd_frac(input logic signed [67:0] x);
        return (x + FRAC_HALF) >>> FRAC_BITS;
    endfunction

    // The two memories: corners in rows 0..2 and normals in rows 3..8 of the geometry
    // store, and the ten control points of the built patch, one point to a row.
    logic [95:0] geo_mem [GEO_ROWS];
    logic [95:0] ctrl_mem [CTRL_ROWS];

    logic        geo_we;
    logic [3:0]  geo_waddr;
    logic [3:0]  geo_raddr;
    logic [95:0] geo_rdata_reg;
    logic        ctrl_we;
    logic [3:0]  ctrl_waddr;
    logic [95:0] ctrl_wdata;
    logic [3:0]  ctrl_raddr;
    logic [95:0] ctrl_rdata_reg;

    // Sequencer.
    state_t      state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [2:0]  edge_reg, edge_next;
    logic [1:0]  comp_reg, comp_next;
    logic        centre_reg, centre_next;
    logic        in_acc;

    // Operands latched at acceptance.
    logic [2:0]  straight_reg, straight_next;
    logic [16:0] u_reg, u_next;
    logic [16:0] v_reg, v_next;
    logic [16:0] w_reg, w_next;

    // Edge point datapath.
    logic [95:0]        a_row_reg, a_row_next;
    logic [95:0]        b_row_reg, b_row_next;
    logic [95:0]        n_row_reg, n_row_next;
    logic signed [59:0] dot_acc_reg, dot_acc_next;
    logic signed [31:0] dot_reg, dot_next;
    logic signed [69:0] sum_reg, sum_next;
    logic [32:0]        div_num_reg, div_num_next;
    logic [32:0]        div_quo_reg, div_quo_next;
    logic               neg_reg, neg_next;
    logic [95:0]        row_reg, row_next;
    logic signed [34:0] s_acc_reg [3];
    logic signed [33:0] p_acc_reg [3];

    // Shared multiplier.
    logic signed [34:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [67:0] prod_reg;

    // Weight formation.
    logic        wres_v_reg, wres_v_next;
    logic [3:0]  wres_step_reg, wres_step_next;
    logic [33:0] pair_reg [4];
    logic [26:0] wt_reg [CTRL_ROWS];
    logic [3:0]  wt_idx;
    logic [53:0] wt_scaled;

    // Multiply-accumulate stream.
    logic               mac_issue;
    logic [3:0]         mac_row_reg, mac_row_next;
    logic [1:0]         mac_comp_reg, mac_comp_next;
    logic               mac_v1_reg, mac_v1_next;
    logic [3:0]         mac_row1_reg, mac_row1_next;
    logic [1:0]         mac_comp1_reg, mac_comp1_next;
    logic               mac_v2_reg, mac_v2_next;
    logic [1:0]         mac_comp2_reg, mac_comp2_next;
    logic signed [61:0] acc_reg [3];

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic signed [31:0] px_reg, py_reg, pz_reg;

    // Scratch values.
    logic signed [31:0] ca, cb, cn;
    logic signed [67:0] term;
    logic [69:0]        mag;
    logic [69:0]        biased;
    logic [66:0]        q_wide;
    logic [32:0]        q_neg;
    logic signed [31:0] res;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign point_x   = px_reg;
    assign point_y   = py_reg;
    assign point_z   = pz_reg;
    assign out_load  = (state_reg == ST_EOUT) && (!out_valid_reg || out_ready);
    assign mac_issue = (state_reg == ST_EMAC) && (cnt_reg < 6'(MAC_STEPS));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg + 6'd1;
        edge_next   = edge_reg;
        comp_next   = comp_reg;
        centre_next = centre_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = 6'd0;
                if (in_acc && (operation == OP_BUILD)) begin
                    state_next  = ST_CPY;
                    centre_next = 1'b0;
                end
                else if (in_acc && (operation == OP_EVAL)) begin
                    state_next = ST_EWGT;
                end
            end
            ST_CPY:
            begin
                if (cnt_reg == 6'd3) begin
                    state_next = ST_ELD;
                    cnt_next   = 6'd0;
                    edge_next  = 3'd0;
                end
            end
            ST_ELD:
            begin
                if (cnt_reg == 6'd3) begin
                    state_next = ST_EDOT;
                    cnt_next   = 6'd0;
                end
            end
            ST_EDOT:
            begin
                if (cnt_reg == 6'd4) begin
                    state_next = ST_ETERM;
                    comp_next  = 2'd0;
                end
            end
            ST_ETERM: state_next = ST_EPREP;
            ST_EPREP: state_next = ST_MAG;
            ST_CPREP: state_next = ST_MAG;
            ST_MAG:
            begin
                state_next = ST_DIV;
                cnt_next   = 6'd0;
            end
            ST_DIV:
            begin
                if (cnt_reg == 6'(DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (comp_reg != 2'd2) begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = centre_reg ? ST_CPREP : ST_ETERM;
                end
                else if (centre_reg) begin
                    state_next = ST_IDLE;
                end
                else if (edge_reg == 3'(NUM_EDGES - 1)) begin
                    state_next  = ST_CPREP;
                    comp_next   = 2'd0;
                    centre_next = 1'b1;
                end
                else begin
                    edge_next  = edge_reg + 3'd1;
                    state_next = ST_ELD;
                    cnt_next   = 6'd0;
                end
            end
            ST_EWGT:
            begin
                if (cnt_reg == 6'(WGT_STEPS)) begin
                    state_next = ST_EMAC;
                    cnt_next   = 6'd0;
                end
            end
            ST_EMAC:
            begin
                if (cnt_reg == 6'(MAC_STEPS + 1)) begin
                    state_next = ST_EOUT;
                end
            end
            ST_EOUT:
            begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        geo_we     = in_acc && (((operation == OP_LOAD_CORNER) && (slot < 3'(NUM_CORNERS))) ||
                               ((operation == OP_LOAD_NORMAL) && (slot < 3'(NUM_NORMALS))));
        geo_waddr  = 4'(slot) + ((operation == OP_LOAD_NORMAL) ? 4'(NORMAL_BASE) : 4'd0);
        geo_raddr  = cnt_reg[3:0];
        ctrl_we    = 1'b0;
        ctrl_waddr = cnt_reg[3:0] - 4'd1;
        ctrl_wdata = geo_rdata_reg;
        ctrl_raddr = mac_row_reg;

        straight_next = in_acc ? straight_edges : straight_reg;
        u_next        = in_acc ? clamp_bary(bary_u) : u_reg;
        v_next        = in_acc ? clamp_bary(bary_v) : v_reg;
        w_next        = in_acc ? clamp_bary(bary_w) : w_reg;

        a_row_next   = a_row_reg;
        b_row_next   = b_row_reg;
        n_row_next   = n_row_reg;
        dot_acc_next = dot_acc_reg;
        dot_next     = dot_reg;
        sum_next     = sum_reg;
        div_num_next = div_num_reg;
        div_quo_next = div_quo_reg;
        neg_next     = neg_reg;
        row_next     = row_reg;
        mul_a        = '0;
        mul_b        = '0;

        ca     = comp_of(a_row_reg, comp_reg);
        cb     = comp_of(b_row_reg, comp_reg);
        cn     = comp_of(n_row_reg, comp_reg);
        term   = straight_reg[edge_flag(edge_reg)] ? 68'sd0 : rnd_frac(prod_reg);
        mag    = sum_reg[69] ? 70'(-sum_reg) : 70'(sum_reg);
        biased = centre_reg ? ((mag + 70'd6) >> 2) : (mag + 70'd1);
        q_wide = 67'({div_num_reg, 32'd0}) + 67'(prod_reg[64:0]);
        q_neg  = ~div_quo_reg + 33'd1;
        if (neg_reg) begin
            res = q_neg[31:0];
        end
        else begin
            res = div_quo_reg[31] ? SAT_MAX : div_quo_reg[31:0];
        end

        case (state_reg)
            ST_CPY:
            begin
                ctrl_we = (cnt_reg != 6'd0);
            end
            ST_ELD:
            begin
                case (cnt_reg[1:0])
                    2'd0:    geo_raddr = 4'(edge_from(edge_reg));
                    2'd1:    geo_raddr = 4'(edge_to(edge_reg));
                    default: geo_raddr = 4'(edge_nrm(edge_reg)) + 4'(NORMAL_BASE);
                endcase
                if (cnt_reg == 6'd1) begin
                    a_row_next = geo_rdata_reg;
                end
                if (cnt_reg == 6'd2) begin
                    b_row_next = geo_rdata_reg;
                end
                if (cnt_reg == 6'd3) begin
                    n_row_next = geo_rdata_reg;
                end
            end
            ST_EDOT:
            begin
                // Component k is multiplied at count k and summed at count k+1.
                mul_a = 35'(comp_of(n_row_reg, cnt_reg[1:0]));
                mul_b = 33'(comp_of(b_row_reg, cnt_reg[1:0]))
                      - 33'(comp_of(a_row_reg, cnt_reg[1:0]));
                if (cnt_reg == 6'd0) begin
                    dot_acc_next = '0;
                end
                else if (cnt_reg != 6'd4) begin
                    dot_acc_next = dot_acc_reg + 60'(rnd_frac(prod_reg));
                end
                else begin
                    dot_next = sat32(70'(dot_acc_reg));
                end
            end
            ST_ETERM:
            begin
                mul_a = 35'(cn);
                mul_b = 33'(dot_reg);
            end
            ST_EPREP:
            begin
                sum_next = (70'(ca) <<< 1) + 70'(cb) - 70'(term);
            end
            ST_CPREP:
            begin
                sum_next = (70'(s_acc_reg[comp_reg]) <<< 1) + 70'(s_acc_reg[comp_reg])
                         - (70'(p_acc_reg[comp_reg]) <<< 1);
            end
            ST_MAG:
            begin
                // Values past the clamp all saturate, so the divider never needs more.
                neg_next     = sum_reg[69];
                div_num_next = (biased > 70'(DIV_LIMIT)) ? DIV_LIMIT : biased[32:0];
                div_quo_next = '0;
            end
            ST_DIV:
            begin
                // Divide by three as a multiply by 2^34/3 rounded up, which is exact for
                // every numerator up to the clamp. The product of count 0 is taken at count 1.
                mul_a = 35'(div_num_reg);
                mul_b = RECIP3_LOW;
                if (cnt_reg == 6'(DIV_STEPS - 1)) begin
                    div_quo_next = q_wide[66:34];
                end
            end
            ST_FIN:
            begin
                case (comp_reg)
                    2'd0:    row_next = {row_reg[95:32], res};
                    2'd1:    row_next = {row_reg[95:64], res, row_reg[31:0]};
                    default: row_next = {res, row_reg[63:0]};
                endcase
                if (comp_reg == 2'd2) begin
                    ctrl_we    = 1'b1;
                    ctrl_waddr = centre_reg ? 4'(CENTRE_ROW)
                                            : 4'(edge_reg) + 4'(FIRST_EDGE_ROW);
                    ctrl_wdata = {res, row_reg[63:0]};
                end
            end
            ST_EWGT:
            begin
                // Four pair products first, then the ten cubic monomials.
                case (cnt_reg)
                    6'd0:
                    begin
                        mul_a = 35'(u_reg);
                        mul_b = 33'(u_reg);
                    end
                    6'd1:
                    begin
                        mul_a = 35'(v_reg);
                        mul_b = 33'(v_reg);
                    end
                    6'd2:
                    begin
                        mul_a = 35'(w_reg);
                        mul_b = 33'(w_reg);
                    end
                    6'd3:
                    begin
                        mul_a = 35'(u_reg);
                        mul_b = 33'(v_reg);
                    end
                    6'd4:
                    begin
                        mul_a = 35'(pair_reg[0]);
                        mul_b = 33'(u_reg);
                    end
                    6'd5:
                    begin
                        mul_a = 35'(pair_reg[1]);
                        mul_b = 33'(v_reg);
                    end
                    6'd6:
                    begin
                        mul_a = 35'(pair_reg[2]);
                        mul_b = 33'(w_reg);
                    end
                    6'd7:
                    begin
                        mul_a = 35'(pair_reg[0]);
                        mul_b = 33'(v_reg);
                    end
                    6'd8:
                    begin
                        mul_a = 35'(pair_reg[1]);
                        mul_b = 33'(u_reg);
                    end
                    6'd9:
                    begin
                        mul_a = 35'(pair_reg[1]);
                        mul_b = 33'(w_reg);
                    end
                    6'd10:
                    begin
                        mul_a = 35'(pair_reg[2]);
                        mul_b = 33'(v_reg);
                    end
                    6'd11:
                    begin
                        mul_a = 35'(pair_reg[2]);
                        mul_b = 33'(u_reg);
                    end
                    6'd12:
                    begin
                        mul_a = 35'(pair_reg[0]);
                        mul_b = 33'(w_reg);
                    end
                    6'd13:
                    begin
                        mul_a = 35'(pair_reg[3]);
                        mul_b = 33'(w_reg);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_EMAC:
            begin
                mul_a = 35'(comp_of(ctrl_rdata_reg, mac_comp1_reg));
                mul_b = 33'(wt_reg[mac_row1_reg]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        // Weight formation stage, fed from the registered multiplier product.
        wres_v_next    = (state_reg == ST_EWGT) && (cnt_reg < 6'(WGT_STEPS));
        wres_step_next = cnt_reg[3:0];
        wt_idx         = wres_step_reg - 4'd4;
        if (wt_idx < 4'd3) begin
            wt_scaled = 54'(prod_reg[50:0]);
        end
        else if (wt_idx < 4'd9) begin
            wt_scaled = (54'(prod_reg[50:0]) << 1) + 54'(prod_reg[50:0]);
        end
        else begin
            wt_scaled = (54'(prod_reg[50:0]) << 2) + (54'(prod_reg[50:0]) << 1);
        end

        // Multiply-accumulate stream: address, then operand, then sum.
        mac_row_next  = mac_row_reg;
        mac_comp_next = mac_comp_reg;
        if (state_reg == ST_EWGT) begin
            mac_row_next  = 4'd0;
            mac_comp_next = 2'd0;
        end
        else if (mac_issue) begin
            if (mac_comp_reg == 2'd2) begin
                mac_comp_next = 2'd0;
                mac_row_next  = mac_row_reg + 4'd1;
            end
            else begin
                mac_comp_next = mac_comp_reg + 2'd1;
            end
        end
        mac_v1_next    = mac_issue;
        mac_row1_next  = mac_row_reg;
        mac_comp1_next = mac_comp_reg;
        mac_v2_next    = mac_v1_reg;
        mac_comp2_next = mac_comp1_reg;

        if (out_load) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (geo_we) begin
            geo_mem[geo_waddr] <= {coord_z, coord_y, coord_x};
        end
        geo_rdata_reg <= geo_mem[geo_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_we) begin
            ctrl_mem[ctrl_waddr] <= ctrl_wdata;
        end
        ctrl_rdata_reg <= ctrl_mem[ctrl_raddr];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            wres_v_reg    <= 1'b0;
            mac_v1_reg    <= 1'b0;
            mac_v2_reg    <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            wres_v_reg    <= wres_v_next;
            mac_v1_reg    <= mac_v1_next;
            mac_v2_reg    <= mac_v2_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        edge_reg      <= edge_next;
        comp_reg      <= comp_next;
        centre_reg    <= centre_next;
        straight_reg  <= straight_next;
        u_reg         <= u_next;
        v_reg         <= v_next;
        w_reg         <= w_next;
        a_row_reg     <= a_row_next;
        b_row_reg     <= b_row_next;
        n_row_reg     <= n_row_next;
        dot_acc_reg   <= dot_acc_next;
        dot_reg       <= dot_next;
        sum_reg       <= sum_next;
        div_num_reg   <= div_num_next;
        div_quo_reg   <= div_quo_next;
        neg_reg       <= neg_next;
        row_reg       <= row_next;
        prod_reg      <= mul_a * mul_b;
        wres_step_reg <= wres_step_next;
        mac_row_reg   <= mac_row_next;
        mac_comp_reg  <= mac_comp_next;
        mac_row1_reg  <= mac_row1_next;
        mac_comp1_reg <= mac_comp1_next;
        mac_comp2_reg <= mac_comp2_next;

        // Corner and edge point sums feed the centre point.
        if (in_acc && (operation == OP_BUILD)) begin
            for (int c = 0; c < 3; c++) begin
                p_acc_reg[c] <= '0;
                s_acc_reg[c] <= '0;
            end
        end
        else if ((state_reg == ST_CPY) && (cnt_reg != 6'd0)) begin
            for (int c = 0; c < 3; c++) begin
                p_acc_reg[c] <= p_acc_reg[c] + 34'(comp_of(geo_rdata_reg, 2'(c)));
            end
        end
        if ((state_reg == ST_FIN) && !centre_reg) begin
            s_acc_reg[comp_reg] <= s_acc_reg[comp_reg] + 35'(res);
        end

        if (wres_v_reg) begin
            if (wres_step_reg < 4'd4) begin
                pair_reg[wres_step_reg[1:0]] <= prod_reg[33:0];
            end
            else begin
                wt_reg[wt_idx] <= 27'((wt_scaled + 54'(1 << (WEIGHT_FRAC - 1))) >> WEIGHT_FRAC);
            end
        end

        if (state_reg == ST_EWGT) begin
            for (int c = 0; c < 3; c++) begin
                acc_reg[c] <= '0;
            end
        end
        else if (mac_v2_reg) begin
            acc_reg[mac_comp2_reg] <= acc_reg[mac_comp2_reg] + prod_reg[61:0];
        end

        if (out_load) begin
            px_reg <= sat32(70'((acc_reg[0] + WGT_HALF) >>> WEIGHT_FRAC));
            py_reg <= sat32(70'((acc_reg[1] + WGT_HALF) >>> WEIGHT_FRAC));
            pz_reg <= sat32(70'((acc_reg[2] + WGT_HALF) >>> WEIGHT_FRAC));
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_geo_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        geo_we |-> (state_reg == ST_IDLE))
        else $error("geometry store written outside idle");

    a_ctrl_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_we |-> ((state_reg == ST_CPY) || (state_reg == ST_FIN)))
        else $error("control point store written outside build");

    a_quotient_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> (div_quo_reg <= 33'h0_8000_0000))
        else $error("divide by three quotient beyond clamp");

    a_mac_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (mac_v2_reg || wres_v_reg) |->
            ((state_reg == ST_EMAC) || (state_reg == ST_EWGT)))
        else $error("multiplier result consumed outside evaluate");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EOUT) && out_valid_reg && !out_ready) |=>
            (state_reg == ST_EOUT))
        else $error("evaluate result dropped while output stalled");

endmodule
